// ===== rtl/core/buddy_page_allocator_assert.svh =====
// Assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// hold cond in the same cycle as trig
`define BPA_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("buddy page allocator check failed");

// hold cond in the cycle after trig
`define BPA_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("buddy page allocator check failed");

`endif

// ===== rtl/core/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;
  localparam int ADDR_W = 48;
  localparam int CNT_W = 11;
  localparam int NEED_W = 5;
  localparam int NUM_FRAMES_DEF = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int DATA_W = 64;
  localparam int PADDR_W = 4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic REG_BASE = 1'b0;

  typedef struct packed {
    logic              command;
    logic [CNT_W-1:0]  page_count;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_address;
  } rsp_t;

  // smallest order whose block holds cnt pages; zero counts as one page
  function automatic logic [NEED_W-1:0] need_order(input logic [CNT_W-1:0] cnt);
    logic [NEED_W-1:0] k;
    k = NEED_W'(CNT_W);
    for (int j = CNT_W - 1; j >= 0; j--) begin
      if (((CNT_W + 1)'(1) << j) >= {1'b0, cnt}) begin
        k = NEED_W'(j);
      end
    end
    return k;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/bpa_frame_ram.sv =====
`default_nettype none
module bpa_frame_ram #(
  parameter int AW = 10,
  parameter int WW = 5
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] addr,
  input  wire logic          we,
  input  wire logic [WW-1:0] wdata,
  output logic      [WW-1:0] rdata
);
  logic [WW-1:0] mem [0:(1 << AW) - 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/bpa_ctrl.sv =====
`default_nettype none
module bpa_ctrl #(
  parameter int NUM_FRAMES = bpa_pkg::NUM_FRAMES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [bpa_pkg::ADDR_W-1:0] base,
  input  wire logic                      req_valid,
  output logic                           req_ready,
  input  wire bpa_pkg::req_t             req,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output bpa_pkg::rsp_t                  res
);
  localparam int MAX_ORDER = $clog2(NUM_FRAMES + 1) - 1;
  localparam int FW = MAX_ORDER;
  localparam int POOL = 1 << MAX_ORDER;
  localparam int OW = $clog2(MAX_ORDER + 2);
  localparam int WW = OW + 1;
  localparam int AW = bpa_pkg::ADDR_W;
  localparam logic [OW-1:0] NONE = {OW{1'b1}};
  localparam logic [OW-1:0] MAXO = OW'(MAX_ORDER);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ARD   = 4'd2;
  localparam logic [3:0] S_AEV   = 4'd3;
  localparam logic [3:0] S_ASPL  = 4'd4;
  localparam logic [3:0] S_FCHK  = 4'd5;
  localparam logic [3:0] S_FEV   = 4'd6;
  localparam logic [3:0] S_FLOOP = 4'd7;
  localparam logic [3:0] S_FBEV  = 4'd8;
  localparam logic [3:0] S_FEND  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]                  state;
  logic [FW:0]                 cnt;
  logic [FW-1:0]               idx;
  logic [OW-1:0]               ord;
  logic [bpa_pkg::NEED_W-1:0]  need;
  logic                        found;
  logic [FW-1:0]               bidx;
  logic [OW-1:0]               bord;
  logic [AW-1:0]               addr_in;

  logic [FW-1:0] ram_addr;
  logic          ram_we;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] ram_rdata;
  logic [OW-1:0] rd_ord;
  logic          rd_used;

  logic [bpa_pkg::NEED_W-1:0] need_new;
  logic [FW:0]                scan_next;
  logic                       hit;
  logic                       exact;
  logic [AW-1:0]              off;
  logic                       bad_free;
  logic [FW-1:0]              ord_bit;
  logic [OW-1:0]              ord_dn;
  logic [FW-1:0]              dn_bit;

  bpa_frame_ram #(.AW(FW), .WW(WW)) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_ord    = ram_rdata[WW-1:1];
  assign rd_used   = ram_rdata[0];
  assign need_new  = bpa_pkg::need_order(req.page_count);
  assign scan_next = cnt + ((FW + 1)'(1) << rd_ord);
  assign hit   = !rd_used && (int'(rd_ord) >= int'(need))
                 && (!found || rd_ord < bord);
  assign exact = !rd_used && (int'(rd_ord) == int'(need));
  assign off   = addr_in - base;
  assign bad_free = (addr_in < base) || (off[bpa_pkg::PAGE_SHIFT-1:0] != '0)
                    || ((off >> (bpa_pkg::PAGE_SHIFT + FW)) != '0);
  assign ord_bit = FW'(1) << ord;
  assign ord_dn  = ord - OW'(1);
  assign dn_bit  = FW'(1) << ord_dn;
  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    ram_addr  = cnt[FW-1:0];
    ram_we    = 1'b0;
    ram_wdata = {NONE, 1'b0};
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = (cnt == '0) ? {MAXO, 1'b0} : {NONE, 1'b0};
      end
      S_ASPL: begin
        ram_we = 1'b1;
        if (int'(ord) > int'(need)) begin
          ram_addr  = idx + dn_bit;
          ram_wdata = {ord_dn, 1'b0};
        end else begin
          ram_addr  = idx;
          ram_wdata = {OW'(need), 1'b1};
        end
      end
      S_FCHK: ram_addr = off[bpa_pkg::PAGE_SHIFT +: FW];
      S_FLOOP: ram_addr = idx ^ ord_bit;
      S_FBEV: begin
        ram_addr  = idx | ord_bit;
        ram_we    = (rd_ord == ord) && !rd_used;
        ram_wdata = {NONE, 1'b0};
      end
      S_FEND: begin
        ram_addr  = idx;
        ram_we    = 1'b1;
        ram_wdata = {ord, 1'b0};
      end
      default: ram_addr = cnt[FW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt   <= '0;
      found <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          cnt <= cnt + (FW + 1)'(1);
          if (cnt == (FW + 1)'(POOL - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            res.result_address <= '0;
            if (req.command == bpa_pkg::CMD_ALLOC) begin
              need  <= need_new;
              cnt   <= '0;
              found <= 1'b0;
              if (int'(need_new) > MAX_ORDER) begin
                res.status <= bpa_pkg::ST_NOSPACE;
                state      <= S_DONE;
              end else begin
                state <= S_ARD;
              end
            end else begin
              addr_in <= req.block_address;
              state   <= S_FCHK;
            end
          end
        end
        S_ARD: state <= S_AEV;
        S_AEV: begin
          if (hit) begin
            found <= 1'b1;
            bidx  <= cnt[FW-1:0];
            bord  <= rd_ord;
          end
          if (exact) begin
            idx   <= cnt[FW-1:0];
            ord   <= rd_ord;
            state <= S_ASPL;
          end else if (scan_next[FW]) begin
            if (hit) begin
              idx   <= cnt[FW-1:0];
              ord   <= rd_ord;
              state <= S_ASPL;
            end else if (found) begin
              idx   <= bidx;
              ord   <= bord;
              state <= S_ASPL;
            end else begin
              res.status <= bpa_pkg::ST_NOSPACE;
              state      <= S_DONE;
            end
          end else begin
            cnt   <= scan_next;
            state <= S_ARD;
          end
        end
        S_ASPL: begin
          if (int'(ord) > int'(need)) begin
            ord <= ord_dn;
          end else begin
            res.status         <= bpa_pkg::ST_DONE;
            res.result_address <= base + (AW'(idx) << bpa_pkg::PAGE_SHIFT);
            state              <= S_DONE;
          end
        end
        S_FCHK: begin
          idx <= off[bpa_pkg::PAGE_SHIFT +: FW];
          if (bad_free) begin
            res.status <= bpa_pkg::ST_IGNORED;
            state      <= S_DONE;
          end else begin
            state <= S_FEV;
          end
        end
        S_FEV: begin
          ord <= rd_ord;
          if (rd_ord == NONE || !rd_used) begin
            res.status <= bpa_pkg::ST_IGNORED;
            state      <= S_DONE;
          end else begin
            state <= S_FLOOP;
          end
        end
        S_FLOOP: begin
          if (int'(ord) < MAX_ORDER) begin
            state <= S_FBEV;
          end else begin
            state <= S_FEND;
          end
        end
        S_FBEV: begin
          if (rd_ord == ord && !rd_used) begin
            idx   <= idx & ~ord_bit;
            ord   <= ord + OW'(1);
            state <= S_FLOOP;
          end else begin
            state <= S_FEND;
          end
        end
        S_FEND: begin
          res.status <= bpa_pkg::ST_DONE;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/buddy_page_allocator.sv =====
// Channel   Handshake            Word
// req       req_valid/req_ready  req_t: command, page_count, block_address
// rsp       rsp_valid/rsp_ready  rsp_t: status, result_address
// apb       psel/penable/pready  base_address at byte address 0
//
// After reset the frame table's 2^floor(log2(NUM_FRAMES)) entries are cleared.
// Allocate: walks the block heads for the best fit, then splits it down; the
// frame table is single-port with a registered read.
// Free: checks the address, then merges with free buddies up to the top order;
// an ignored free ends after the checks.
// The next word is taken while a result waits in the output register.
`default_nettype none
module buddy_page_allocator #(
  parameter int NUM_FRAMES = bpa_pkg::NUM_FRAMES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bpa_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bpa_pkg::DATA_W-1:0]  pwdata,
  output logic      [bpa_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire bpa_pkg::req_t               req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output bpa_pkg::rsp_t                    rsp
);
  logic [bpa_pkg::ADDR_W-1:0] base_address;
  logic                       res_valid;
  logic                       res_ready;
  bpa_pkg::rsp_t              res;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == bpa_pkg::REG_BASE)
                  ? bpa_pkg::DATA_W'(base_address) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[3] == bpa_pkg::REG_BASE) begin
      base_address <= pwdata[bpa_pkg::ADDR_W-1:0];
    end
  end

  bpa_ctrl #(.NUM_FRAMES(NUM_FRAMES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .base      (base_address),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

  `include "buddy_page_allocator_assert.svh"

  `BPA_ASSERT_NOW(a_status_code, rsp_valid, rsp.status <= bpa_pkg::ST_IGNORED)
  `BPA_ASSERT_NOW(a_fail_zero_addr, rsp_valid && rsp.status != bpa_pkg::ST_DONE,
                  rsp.result_address == '0)
  `BPA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
endmodule
`default_nettype wire
